>>> hdl/rgbhsv_pkg.sv
// rgbhsv_pkg: shared types and constants of the rgb to hsv pixel converter
// used by the front stage, the divider cells and the top level; no dependencies

`default_nettype none

package rgbhsv_pkg;

    // channel and result widths
    localparam int CHAN_W   = 8;
    localparam int HUE_W    = 9;
    localparam int PCT_W    = 7;

    // divider geometry: 9 quotient bits, dividend of remainder plus quotient bits
    localparam int DIV_STEPS = HUE_W;
    localparam int ACC_W     = CHAN_W + DIV_STEPS;
    localparam int TOT_W     = ACC_W + 2;

    // hue arithmetic constants, signed at the width of the scaled hue
    localparam logic signed [TOT_W-1:0] HUE_OFS_GREEN = TOT_W'(120);
    localparam logic signed [TOT_W-1:0] HUE_OFS_BLUE  = TOT_W'(240);
    localparam logic signed [TOT_W-1:0] DEG_SECTOR    = TOT_W'(60);
    localparam logic signed [TOT_W-1:0] DEG_CIRCLE    = TOT_W'(360);

    // percent scale and reciprocal of full scale (x / 255 == ((x + 1) * 257) >> 16)
    localparam logic [ACC_W-1:0] PERCENT    = ACC_W'(100);
    localparam logic [23:0]      RECIP_FULL = 24'd257;
    localparam int               RECIP_SH   = 16;

    // which channel holds the maximum
    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } sector_t;

    // after max/min search
    typedef struct packed {
        logic [CHAN_W-1:0]        mx;
        logic [CHAN_W-1:0]        spread;
        logic signed [CHAN_W:0]   diff;
        sector_t                  sector;
    } sort_t;

    // payload handed from cell to cell
    typedef struct packed {
        logic [ACC_W-1:0]  hue_acc;
        logic [CHAN_W-1:0] hue_div;
        logic [ACC_W-1:0]  sat_acc;
        logic [CHAN_W-1:0] sat_div;
        logic [PCT_W-1:0]  bright;
        logic              flat;
    } cell_t;

endpackage

`default_nettype wire

>>> hdl/rgbhsv_front.sv
// rgbhsv_front: two register stages that sort the channels and set up the dividends
// depends on rgbhsv_pkg

`default_nettype none

module rgbhsv_front
    import rgbhsv_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [CHAN_W-1:0] red,
    input  wire logic [CHAN_W-1:0] green,
    input  wire logic [CHAN_W-1:0] blue,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output cell_t                  out_data
);

    logic  sort_valid_reg;
    logic  sort_ready;
    sort_t sort_reg;
    sort_t sort_next;

    logic  prep_valid_reg;
    cell_t prep_reg;
    cell_t prep_next;

    logic signed [TOT_W-1:0] d_s;
    logic signed [TOT_W-1:0] diff_s;
    logic signed [TOT_W-1:0] ofs_s;
    logic signed [TOT_W-1:0] tot_s;
    logic [ACC_W-1:0]        mx_pct;
    logic [23:0]             bright_prod;

    // per-stage ready: a stage takes an item when empty or when its item moves on
    assign sort_ready = !prep_valid_reg || out_ready;
    assign in_ready   = !sort_valid_reg || sort_ready;
    assign out_valid  = prep_valid_reg;
    assign out_data   = prep_reg;

    // max channel with red over green over blue on ties, spread and signed difference
    always_comb
    begin
        sort_next = '0;
        if (red >= green && red >= blue)
        begin
            sort_next.sector = SECT_RED;
            sort_next.mx     = red;
            sort_next.diff   = $signed({1'b0, green}) - $signed({1'b0, blue});
        end
        else if (green >= blue)
        begin
            sort_next.sector = SECT_GREEN;
            sort_next.mx     = green;
            sort_next.diff   = $signed({1'b0, blue}) - $signed({1'b0, red});
        end
        else
        begin
            sort_next.sector = SECT_BLUE;
            sort_next.mx     = blue;
            sort_next.diff   = $signed({1'b0, red}) - $signed({1'b0, green});
        end
        if (red <= green && red <= blue)
        begin
            sort_next.spread = sort_next.mx - red;
        end
        else if (green <= blue)
        begin
            sort_next.spread = sort_next.mx - green;
        end
        else
        begin
            sort_next.spread = sort_next.mx - blue;
        end
    end

    // hue scaled by the spread, wrapped into one turn; saturation dividend and value in percent
    always_comb
    begin
        d_s    = TOT_W'(sort_reg.spread);
        diff_s = TOT_W'(sort_reg.diff);
        case (sort_reg.sector)
            SECT_RED:   ofs_s = '0;
            SECT_GREEN: ofs_s = HUE_OFS_GREEN * d_s;
            SECT_BLUE:  ofs_s = HUE_OFS_BLUE * d_s;
            default:    ofs_s = '0;
        endcase
        tot_s = ofs_s + DEG_SECTOR * diff_s;
        if (tot_s[TOT_W-1])
        begin
            tot_s = tot_s + DEG_CIRCLE * d_s;
        end

        mx_pct      = ACC_W'(sort_reg.mx) * PERCENT;
        bright_prod = (24'(mx_pct) + 24'd1) * RECIP_FULL;

        prep_next.hue_acc = ACC_W'(tot_s);
        prep_next.hue_div = sort_reg.spread;
        prep_next.sat_acc = ACC_W'(sort_reg.spread) * PERCENT;
        prep_next.sat_div = sort_reg.mx;
        prep_next.bright  = bright_prod[RECIP_SH +: PCT_W];
        prep_next.flat    = (sort_reg.spread == '0);
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sort_valid_reg <= 1'b0;
            prep_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                sort_valid_reg <= in_valid;
            end
            if (sort_ready)
            begin
                prep_valid_reg <= sort_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            sort_reg <= sort_next;
        end
        if (sort_ready && sort_valid_reg)
        begin
            prep_reg <= prep_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/rgbhsv_div_cell.sv
// rgbhsv_div_cell: one restoring-division step for hue and saturation, registered
// depends on rgbhsv_pkg

`default_nettype none

module rgbhsv_div_cell
    import rgbhsv_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire cell_t in_data,
    output logic       out_valid,
    input  wire logic  out_ready,
    output cell_t      out_data
);

    logic  valid_reg;
    cell_t data_reg;
    cell_t data_next;

    // acc holds {partial remainder, dividend bits not yet used / quotient bits so far}
    function automatic logic [ACC_W-1:0] div_step(input logic [ACC_W-1:0] acc,
                                                  input logic [CHAN_W-1:0] div);
        logic [CHAN_W:0] trial;
        logic [CHAN_W:0] rem;
        logic            ge;
        trial = acc[ACC_W-1 -: CHAN_W+1];
        ge    = (trial >= {1'b0, div});
        rem   = ge ? (trial - {1'b0, div}) : trial;
        return {rem[CHAN_W-1:0], acc[DIV_STEPS-2:0], ge};
    endfunction

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // one quotient bit for each divider
    always_comb
    begin
        data_next         = in_data;
        data_next.hue_acc = div_step(in_data.hue_acc, in_data.hue_div);
        data_next.sat_acc = div_step(in_data.sat_acc, in_data.sat_div);
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/rgb_to_hsv_pixel_converter_core.sv
// rgb_to_hsv_pixel_converter_core: rgb888 pixel in, hue / saturation / value out
// depends on rgbhsv_pkg, rgbhsv_front and rgbhsv_div_cell
//
// usage
//   slave channel s_*: one rgb888 pixel per item, red in the low byte
//   master channel m_*: hue 0..359 degrees, saturation and value 0..100 percent
//   an item moves when tvalid and tready are both high at a rising clock edge
// pipeline
//   two front stages (max/min search, dividend setup) followed by a chain
//   of 9 division cells, one quotient bit each
// throughput
//   one item per clock while the receiver is ready; every stage holds its
//   own item, so a full chain streams without bubbles
// stall
//   each stage takes a new item when empty or when its item moves on, so a
//   stalled receiver fills the chain from the output end; the input stays
//   ready while any stage has room, and a waiting result is held unchanged
// reset
//   rst_n clears all valid flags; no pixel state is kept between items

`default_nettype none

module rgb_to_hsv_pixel_converter_core
    import rgbhsv_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // hue [8:0], saturation [15:9], brightness [22:16], zero [23]
);

    cell_t link_data  [DIV_STEPS+1];
    logic  link_valid [DIV_STEPS+1];
    logic  link_ready [DIV_STEPS+1];

    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] saturation;
    logic [PCT_W-1:0] brightness;

    // channel sort and dividend setup
    rgbhsv_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .red       (s_tdata[7:0]),
        .green     (s_tdata[15:8]),
        .blue      (s_tdata[23:16]),
        .out_valid (link_valid[0]),
        .out_ready (link_ready[0]),
        .out_data  (link_data[0])
    );

    // chain of division cells
    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_cell
        rgbhsv_div_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (link_valid[i]),
            .in_ready  (link_ready[i]),
            .in_data   (link_data[i]),
            .out_valid (link_valid[i+1]),
            .out_ready (link_ready[i+1]),
            .out_data  (link_data[i+1])
        );
    end

    assign link_ready[DIV_STEPS] = m_tready;

    // zero spread gives hue 0 and saturation 0
    always_comb
    begin
        hue        = link_data[DIV_STEPS].flat ? '0 : link_data[DIV_STEPS].hue_acc[HUE_W-1:0];
        saturation = link_data[DIV_STEPS].flat ? '0 : link_data[DIV_STEPS].sat_acc[PCT_W-1:0];
        brightness = link_data[DIV_STEPS].bright;
    end

    assign m_tvalid = link_valid[DIV_STEPS];
    assign m_tdata  = {1'b0, brightness, saturation, hue};

endmodule

`default_nettype wire

>>> hdl/rgbhsv_checker.sv
// rgbhsv_checker: port-level assertions for the rgb to hsv converter
// bound to rgb_to_hsv_pixel_converter_core; no package dependencies

`default_nettype none

module rgbhsv_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [23:0] s_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // hue stays below a full turn
    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[8:0] < 9'd360)
        else $error("hue out of range");

    // percentages never exceed 100
    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[15:9] <= 7'd100) && (m_tdata[22:16] <= 7'd100))
        else $error("saturation or value out of range");

    // an empty output end means every stage can take an item
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input not ready with output empty");

endmodule

bind rgb_to_hsv_pixel_converter_core rgbhsv_checker u_rgbhsv_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
